FILE: rtl/cll_pkg.sv
// Shared types and constants for the cursor linked list engine.
`timescale 1ns / 1ps

package cll_pkg;

  // Default sizing of the slot store and stored values
  localparam int SLOTS_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths on the channels
  localparam int POS_W  = 10;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;

  // Operation kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                     kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] removed_value;
    logic [POS_W-1:0]         list_length;
  } result_t;

endpackage

FILE: rtl/cll_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module cll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds data when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/cursor_linked_list_engine_core.sv
// Cursor linked list engine: array-backed list with a free chain in a link RAM.
// Rejected items go straight to the result; the list walk reads one link per cycle from
//   the link RAM.
// Throughput: one item at a time; the next item is taken while the result waits in its register.
// Reset: synchronous; afterwards a clearing pass writes the initial free chain into the
//   link RAM, during which no item is taken.
`timescale 1ns / 1ps

module cursor_linked_list_engine_core
  import cll_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int AW   = $clog2(SLOTS);
  localparam int CMPW = ((AW > POS_W) ? AW : POS_W) + 1;
  localparam int VW   = (VALUE_BITS > DATA_W) ? VALUE_BITS : DATA_W;

  localparam logic [AW-1:0] DATA_HEAD = AW'(SLOTS - 1);
  localparam logic [AW-1:0] CHAIN_END = AW'(SLOTS - 2);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_FREE     = 3'd2;
  localparam logic [2:0] S_WALK     = 3'd3;
  localparam logic [2:0] S_INS_LINK = 3'd4;
  localparam logic [2:0] S_DEL_NEXT = 3'd5;
  localparam logic [2:0] S_DEL_FREE = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]        state;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     free_head;
  logic [AW-1:0]     count;
  logic [AW-1:0]     steps;
  logic [AW-1:0]     j;
  logic [AW-1:0]     k;
  logic              op_kind;
  logic [STAT_W-1:0] res_status;
  logic [DATA_W-1:0] res_removed;

  // Link RAM port signals
  logic          lk_we;
  logic [AW-1:0] lk_waddr;
  logic [AW-1:0] lk_wdata;
  logic          lk_re;
  logic [AW-1:0] lk_raddr;
  logic [AW-1:0] lk_rdata;

  // Value RAM port signals
  logic                  vs_we;
  logic                  vs_re;
  logic [VALUE_BITS-1:0] vs_wdata;
  logic [VALUE_BITS-1:0] vs_rdata;

  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic            pos_zero;
  logic            ins_bad;
  logic            del_bad;
  logic            store_full;
  logic [VW-1:0]   val_wide;
  logic [VW-1:0]   rem_wide;

  cll_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  cll_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_value_ram (
    .clk   (clk),
    .we    (vs_we),
    .waddr (free_head),
    .wdata (vs_wdata),
    .re    (vs_re),
    .raddr (lk_rdata),
    .rdata (vs_rdata)
  );

  // Range and capacity checks on the incoming item
  assign pos_ext    = CMPW'(item.position);
  assign cnt_ext    = CMPW'(count);
  assign pos_zero   = (item.position == '0);
  assign ins_bad    = pos_zero || (pos_ext > cnt_ext + CMPW'(1));
  assign del_bad    = pos_zero || (pos_ext > cnt_ext);
  assign store_full = (free_head == '0);

  // Fit the value to the stored width and back
  assign val_wide = VW'($unsigned(item.value));
  assign vs_wdata = val_wide[VALUE_BITS-1:0];
  assign rem_wide = VW'(vs_rdata);

  assign item_ready = (state == S_IDLE);

  // Drive the RAM ports from the sequencer state
  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = clr_addr;
    lk_wdata = '0;
    lk_re    = 1'b0;
    lk_raddr = DATA_HEAD;
    vs_we    = 1'b0;
    vs_re    = 1'b0;
    case (state)
      S_CLEAR: begin
        lk_we    = 1'b1;
        lk_waddr = clr_addr;
        lk_wdata = (clr_addr < CHAIN_END) ? clr_addr + AW'(1) : '0;
      end
      S_IDLE: begin
        if (item_valid) begin
          if (item.kind == KIND_INSERT) begin
            if (!ins_bad && !store_full) begin
              vs_we    = 1'b1;
              lk_re    = 1'b1;
              lk_raddr = free_head;
            end
          end else if (!del_bad) begin
            lk_re    = 1'b1;
            lk_raddr = DATA_HEAD;
          end
        end
      end
      S_FREE: begin
        lk_re    = 1'b1;
        lk_raddr = DATA_HEAD;
      end
      S_WALK: begin
        if (steps != '0) begin
          lk_re    = 1'b1;
          lk_raddr = lk_rdata;
        end else if (op_kind == KIND_INSERT) begin
          lk_we    = 1'b1;
          lk_waddr = j;
          lk_wdata = lk_rdata;
        end else begin
          lk_re    = 1'b1;
          lk_raddr = lk_rdata;
          vs_re    = 1'b1;
        end
      end
      S_INS_LINK: begin
        lk_we    = 1'b1;
        lk_waddr = k;
        lk_wdata = j;
      end
      S_DEL_NEXT: begin
        lk_we    = 1'b1;
        lk_waddr = k;
        lk_wdata = lk_rdata;
      end
      S_DEL_FREE: begin
        lk_we    = 1'b1;
        lk_waddr = j;
        lk_wdata = free_head;
      end
      default: begin
        lk_we = 1'b0;
      end
    endcase
  end

  // Sequence each operation and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      free_head    <= AW'(1);
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      // Drop a transferred result unless a new one takes its place
      if (result_valid && result_ready && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == DATA_HEAD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            op_kind     <= item.kind;
            res_removed <= '0;
            j           <= free_head;
            k           <= DATA_HEAD;
            steps       <= AW'(pos_ext - CMPW'(1));
            if (item.kind == KIND_INSERT) begin
              if (ins_bad) begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end else if (store_full) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                state      <= S_FREE;
              end
            end else if (del_bad) begin
              res_status <= ST_RANGE;
              state      <= S_DONE;
            end else begin
              res_status <= ST_OK;
              state      <= S_WALK;
            end
          end
        end
        S_FREE: begin
          free_head <= lk_rdata;
          state     <= S_WALK;
        end
        S_WALK: begin
          if (steps != '0) begin
            k     <= lk_rdata;
            steps <= steps - AW'(1);
          end else if (op_kind == KIND_INSERT) begin
            state <= S_INS_LINK;
          end else begin
            j     <= lk_rdata;
            state <= S_DEL_NEXT;
          end
        end
        S_INS_LINK: begin
          count <= count + AW'(1);
          state <= S_DONE;
        end
        S_DEL_NEXT: begin
          res_removed <= rem_wide[DATA_W-1:0];
          state       <= S_DEL_FREE;
        end
        S_DEL_FREE: begin
          free_head <= j;
          count     <= count - AW'(1);
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid         <= 1'b1;
            result.status        <= res_status;
            result.removed_value <= res_removed;
            result.list_length   <= cnt_ext[POS_W-1:0];
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/cll_checker.sv
// Port-level checker for the cursor linked list engine, bound to the top level.
`timescale 1ns / 1ps

module cll_checker
  import cll_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // Hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Block items while the link store is being initialized
  a_clear_blocks: assert property (@(posedge clk)
    rst |=> !item_ready)
    else $error("item taken during clearing pass");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == ST_OK || result.status == ST_RANGE ||
                      result.status == ST_FULL))
    else $error("undefined status code");

  // A failed operation reports no removed value
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_OK |-> result.removed_value == '0)
    else $error("removed value on failed operation");

  // A full store never shows on a list shorter than one element
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_FULL |-> result.list_length != '0)
    else $error("full status on empty list");

endmodule

bind cursor_linked_list_engine_core cll_checker u_cll_checker (.*);
